@@ rtl/tspat_pkg.sv @@
// ============================================================================
// tspat_pkg - shared types and constants for the PAT section parser
// Result kinds, field widths, and the result beat layout.
// ============================================================================
package tspat_pkg;

    // Result kind codes
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_CRC    = 2'd2;

    // Header byte field masks
    localparam logic [7:0] LEN_HI_MASK  = 8'h03;
    localparam logic [7:0] VERSION_MASK = 8'h3E;
    localparam logic [7:0] SYNTAX_MASK  = 8'h80;

    // Entry count: floor((sec_len - LEN_OVERHEAD) / 4), none below MIN_LEN
    localparam logic [9:0] LEN_OVERHEAD = 10'd9;
    localparam logic [9:0] MIN_LEN      = 10'd13;

    // Last byte index within a header / entry / CRC field
    localparam logic [2:0] HDR_LAST   = 3'd7;
    localparam logic [2:0] FIELD_LAST = 3'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tbl_id;
        logic        syntax_indicator;
        logic [9:0]  sec_len;
        logic [15:0] id_value;
        logic [4:0]  ver_num;
        logic        current_next;
        logic [7:0]  sec_num;
        logic [7:0]  last_sec_num;
        logic [12:0] pid;
        logic [31:0] crc_word;
    } t_result;

    // Section length from the two header length bytes
    function automatic logic [9:0] hdr_len(input logic [63:0] hdr);
        hdr_len = {hdr[49:48], hdr[47:40]};
    endfunction

    // Common header fields; id, pid and crc cleared
    function automatic t_result hdr_result(input logic [63:0] hdr);
        t_result r;
        r                  = '0;
        r.tbl_id           = hdr[63:56];
        r.syntax_indicator = hdr[55];
        r.sec_len          = hdr_len(hdr);
        r.ver_num          = hdr[21:17];
        r.current_next     = hdr[16];
        r.sec_num          = hdr[15:8];
        r.last_sec_num     = hdr[7:0];
        hdr_result         = r;
    endfunction

endpackage

@@ rtl/tspat_if.sv @@
// ============================================================================
// tspat_if - valid/ready channels of the PAT section parser
// Byte input channel and result output channel.
// ============================================================================
interface tspat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       section_start;

    modport source (output valid, output data_byte, output section_start, input ready);
    modport sink   (input valid, input data_byte, input section_start, output ready);
endinterface

interface tspat_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  tbl_id;
    logic        syntax_indicator;
    logic [9:0]  sec_len;
    logic [15:0] id_value;
    logic [4:0]  ver_num;
    logic        current_next;
    logic [7:0]  sec_num;
    logic [7:0]  last_sec_num;
    logic [12:0] pid;
    logic [31:0] crc_word;

    modport source (
        output valid, input ready,
        output kind, output tbl_id, output syntax_indicator, output sec_len,
        output id_value, output ver_num, output current_next,
        output sec_num, output last_sec_num, output pid, output crc_word
    );
    modport sink (
        input valid, output ready,
        input kind, input tbl_id, input syntax_indicator, input sec_len,
        input id_value, input ver_num, input current_next,
        input sec_num, input last_sec_num, input pid, input crc_word
    );
endinterface

@@ rtl/ts_pat_section_parser_unit.sv @@
// A result beat appears on the output in the cycle after the byte that completes it.
// Throughput: one byte beat per cycle while input ready is high; the result register drains while the next byte enters.
// Input ready drops only when a result is held and the output is stalled.
// Reset (i_rst_n low, synchronous): parser goes idle, result register empties.
// ============================================================================
// ts_pat_section_parser_unit - MPEG-2 TS Program Association Table parser
// Takes one section byte per beat, gives a header beat, one beat per program
// entry, and one beat with the CRC field (not checked).
// ============================================================================
module ts_pat_section_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tspat_in_if.sink           i_in,
    tspat_out_if.source        o_out
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_ENTRY,
        PH_CRC
    } t_phase;

    // Parser state
    t_phase      r_phase,   n_phase;
    logic [2:0]  r_cnt,     n_cnt;      // byte index within current field
    logic [7:0]  r_entries, n_entries;  // program entries still to come
    logic [31:0] r_asm,     n_asm;      // entry / CRC assembly
    logic [63:0] r_hdr,     n_hdr;      // eight header bytes

    // Result register
    logic                r_out_valid, n_out_valid;
    tspat_pkg::t_result  r_res,       n_res;

    logic        w_in_ready;
    logic        w_accept;
    logic [63:0] w_hdr_shift;
    logic [9:0]  w_len;
    logic [9:0]  w_len_m9;

    // Take a byte whenever the result register is free or being drained
    assign w_in_ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    // Header as it stands after the current byte, and its length
    assign w_hdr_shift = {r_hdr[55:0], i_in.data_byte};
    assign w_len       = tspat_pkg::hdr_len(w_hdr_shift);
    assign w_len_m9    = w_len - tspat_pkg::LEN_OVERHEAD;

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_entries   = r_entries;
        n_asm       = r_asm;
        n_hdr       = r_hdr;
        n_out_valid = r_out_valid && !o_out.ready;
        n_res       = r_res;

        if (w_accept) begin
            if (i_in.section_start) begin
                // pointer field opens a new section, abandons any current one
                n_phase   = PH_HEADER;
                n_cnt     = '0;
                n_entries = '0;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        n_hdr = w_hdr_shift;
                        if (r_cnt != tspat_pkg::HDR_LAST) begin
                            n_cnt = r_cnt + 3'd1;
                        end else begin
                            n_res          = tspat_pkg::hdr_result(w_hdr_shift);
                            n_res.kind     = tspat_pkg::KIND_HEADER;
                            n_res.id_value = w_hdr_shift[39:24];
                            n_out_valid    = 1'b1;
                            n_entries      = (w_len >= tspat_pkg::MIN_LEN) ? w_len_m9[9:2]
                                                                           : 8'd0;
                            n_phase        = (n_entries != 8'd0) ? PH_ENTRY : PH_CRC;
                            n_cnt          = '0;
                        end
                    end
                    PH_ENTRY, PH_CRC: begin
                        n_asm = {r_asm[23:0], i_in.data_byte};
                        if (r_cnt != tspat_pkg::FIELD_LAST) begin
                            n_cnt = r_cnt + 3'd1;
                        end else begin
                            n_res       = tspat_pkg::hdr_result(r_hdr);
                            n_out_valid = 1'b1;
                            n_cnt       = '0;
                            if (r_phase == PH_ENTRY) begin
                                n_res.kind     = tspat_pkg::KIND_ENTRY;
                                n_res.id_value = n_asm[31:16];
                                n_res.pid      = n_asm[12:0];
                                n_entries      = r_entries - 8'd1;
                                if (n_entries == 8'd0) begin
                                    n_phase = PH_CRC;
                                end
                            end else begin
                                n_res.kind     = tspat_pkg::KIND_CRC;
                                n_res.crc_word = n_asm;
                                n_phase        = PH_IDLE;
                            end
                        end
                    end
                    PH_IDLE: begin
                        // stray bytes ignored until next section start
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_entries   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_entries   <= n_entries;
            r_out_valid <= n_out_valid;
        end
        r_asm <= n_asm;
        r_hdr <= n_hdr;
        r_res <= n_res;
    end

    // Output beat
    assign o_out.valid            = r_out_valid;
    assign o_out.kind             = r_res.kind;
    assign o_out.tbl_id           = r_res.tbl_id;
    assign o_out.syntax_indicator = r_res.syntax_indicator;
    assign o_out.sec_len          = r_res.sec_len;
    assign o_out.id_value         = r_res.id_value;
    assign o_out.ver_num          = r_res.ver_num;
    assign o_out.current_next     = r_res.current_next;
    assign o_out.sec_num          = r_res.sec_num;
    assign o_out.last_sec_num     = r_res.last_sec_num;
    assign o_out.pid              = r_res.pid;
    assign o_out.crc_word         = r_res.crc_word;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.section_start) |=> (r_phase == PH_HEADER && r_cnt == 3'd0))
        else $error("section start did not restart header parse");

    a_entry_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ENTRY) |-> (r_entries != 8'd0))
        else $error("entry phase with no entries left");

    a_field_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ENTRY || r_phase == PH_CRC) |-> (r_cnt <= tspat_pkg::FIELD_LAST))
        else $error("field byte count out of range");

    a_header_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_in.section_start && r_phase == PH_HEADER &&
         r_cnt == tspat_pkg::HDR_LAST)
        |=> (r_out_valid && r_res.kind == tspat_pkg::KIND_HEADER))
        else $error("header beat missing after eighth header byte");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !w_accept)
        else $error("byte taken while result stalled");

endmodule
